[src/bpa_pkg.sv]
// shared constants, types and controller state encoding for the bitmap page allocator
package bpa_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int MAX_PAGES  = 65536;
    localparam int WORD_BITS  = 64;
    localparam int BIT_IDX_W  = $clog2(WORD_BITS);
    localparam int WORDS      = MAX_PAGES / WORD_BITS;
    localparam int WORD_IDX_W = $clog2(WORDS);
    localparam int PAGE_IDX_W = $clog2(MAX_PAGES);
    localparam int CNT_W      = 17;
    localparam int ADDR_W     = 28;
    localparam int CHUNK_BITS = 8;
    localparam int CHUNK_W    = $clog2(WORD_BITS / CHUNK_BITS);
    localparam int CHUNK_OFF_W = $clog2(CHUNK_BITS);
    localparam int IN_DATA_W  = ((CNT_W + ADDR_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ADDR_W + 7) / 8) * 8;

    typedef enum logic
    {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } bpa_cmd_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_ALLOC_RD,
        ST_ALLOC_SCAN,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_DONE
    } bpa_state_t;

    typedef struct packed
    {
        logic clr_wr;
        logic load;
        logic rd;
        logic scan_step;
        logic mark_wr;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic clr_last;
        logic is_free;
        logic zero_cnt;
        logic free_empty;
        logic scan_found;
        logic scan_fail;
        logic word_end;
        logic mark_last;
        logic out_busy;
    } dp_status_t;

endpackage

[src/bpa_ctrl.sv]
// controller state machine sequencing clear, scan, mark and result phases
module bpa_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  bpa_pkg::dp_status_t  status,
    output bpa_pkg::ctrl_cmd_t   cmd
);
    import bpa_pkg::*;

    bpa_state_t state_reg;
    bpa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.is_free)
                begin
                    state_next = status.free_empty ? ST_DONE : ST_MARK_RD;
                end
                else
                begin
                    state_next = status.zero_cnt ? ST_DONE : ST_ALLOC_RD;
                end
            end
            ST_ALLOC_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_ALLOC_SCAN;
            end
            ST_ALLOC_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_found)
                begin
                    state_next = ST_MARK_RD;
                end
                else if (status.scan_fail)
                begin
                    state_next = ST_DONE;
                end
                else if (status.word_end)
                begin
                    state_next = ST_ALLOC_RD;
                end
            end
            ST_MARK_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_MARK_WR;
            end
            ST_MARK_WR:
            begin
                cmd.mark_wr = 1'b1;
                state_next  = status.mark_last ? ST_DONE : ST_MARK_RD;
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/bpa_datapath.sv]
// bitmap memory, chunked run scanner, range mark/clear and result registers
module bpa_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  bpa_pkg::ctrl_cmd_t              cmd,
    output bpa_pkg::dp_status_t             status,
    input  logic [bpa_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bpa_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tuser,
    input  logic                            cfg_valid,
    input  logic [bpa_pkg::CNT_W-1:0]       cfg_data
);
    import bpa_pkg::*;

    logic [WORD_BITS-1:0]  mem [WORDS];
    logic [WORD_BITS-1:0]  rdata_reg;

    logic [WORD_IDX_W-1:0] w_reg;
    logic [CHUNK_W-1:0]    c_reg;
    logic [CNT_W-1:0]      len_reg;
    logic [CNT_W-1:0]      start_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      limit_reg;
    logic [CNT_W-1:0]      lo_reg;
    logic [CNT_W-1:0]      hi_reg;
    logic                  set_bits_reg;
    logic                  is_free_reg;
    logic [CNT_W-1:0]      total_reg;
    logic [ADDR_W-1:0]     res_addr_reg;
    logic                  res_ok_reg;
    logic                  out_valid_reg;
    logic [ADDR_W-1:0]     out_addr_reg;
    logic                  out_ok_reg;

    // request fields
    logic [CNT_W-1:0]      in_cnt;
    logic [ADDR_W-1:0]     in_base;
    logic [CNT_W-1:0]      limit_calc;
    logic [ADDR_W:0]       base_up;
    logic [CNT_W-1:0]      free_first;
    logic [CNT_W:0]        free_end;
    logic [CNT_W-1:0]      free_hi;

    // scanner
    logic [CNT_W-1:0]      scan_len;
    logic [CNT_W-1:0]      scan_start;
    logic                  scan_found;
    logic                  scan_stop;
    logic [PAGE_IDX_W-1:0] scan_page;
    logic [CNT_W:0]        alloc_hi_sum;

    // range mark
    logic [CNT_W-1:0]      hi_m1;
    logic [BIT_IDX_W-1:0]  lo_off;
    logic [WORD_BITS-1:0]  mask_lo;
    logic [WORD_BITS-1:0]  mask_hi;
    logic [WORD_BITS-1:0]  mask;
    logic [WORD_BITS-1:0]  wdata;

    assign in_cnt  = s_tdata[CNT_W-1:0];
    assign in_base = s_tdata[CNT_W+ADDR_W-1:CNT_W];

    assign limit_calc = (total_reg > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : total_reg;

    // round the free address up to a whole page, clamp the end at the limit
    assign base_up    = {1'b0, in_base} + (ADDR_W+1)'(PAGE_BYTES - 1);
    assign free_first = CNT_W'(base_up[ADDR_W:PAGE_SHIFT]);
    assign free_end   = {1'b0, free_first} + {1'b0, in_cnt};
    assign free_hi    = (free_end > {1'b0, limit_calc}) ? limit_calc : free_end[CNT_W-1:0];

    always_comb
    begin
        scan_len   = len_reg;
        scan_start = start_reg;
        scan_found = 1'b0;
        scan_stop  = 1'b0;
        scan_page  = '0;
        for (int i = 0; i < CHUNK_BITS; i++)
        begin
            scan_page = {w_reg, c_reg, CHUNK_OFF_W'(0)} | PAGE_IDX_W'(i);
            if (!scan_found && !scan_stop)
            begin
                if ({1'b0, scan_page} >= limit_reg)
                begin
                    scan_stop = 1'b1;
                end
                else if (rdata_reg[{c_reg, CHUNK_OFF_W'(i)}])
                begin
                    scan_len   = '0;
                    scan_start = {1'b0, scan_page} + CNT_W'(1);
                end
                else
                begin
                    scan_len = scan_len + CNT_W'(1);
                    if (scan_len == cnt_reg)
                    begin
                        scan_found = 1'b1;
                    end
                end
            end
        end
    end

    assign alloc_hi_sum = {1'b0, scan_start} + {1'b0, cnt_reg};

    // word mask covering pages lo..hi-1 within the current word
    assign hi_m1   = hi_reg - CNT_W'(1);
    assign lo_off  = (w_reg == lo_reg[PAGE_IDX_W-1:BIT_IDX_W]) ? lo_reg[BIT_IDX_W-1:0] : '0;
    assign mask_lo = {WORD_BITS{1'b1}} << lo_off;
    assign mask_hi = (w_reg == hi_m1[PAGE_IDX_W-1:BIT_IDX_W])
                   ? ({WORD_BITS{1'b1}} >> (BIT_IDX_W'(WORD_BITS - 1) - hi_m1[BIT_IDX_W-1:0]))
                   : {WORD_BITS{1'b1}};
    assign mask    = mask_lo & mask_hi;
    assign wdata   = set_bits_reg ? (rdata_reg | mask) : (rdata_reg & ~mask);

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
        begin
            mem[w_reg] <= {WORD_BITS{1'b1}};
        end
        else if (cmd.mark_wr)
        begin
            mem[w_reg] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[w_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg         <= '0;
            total_reg     <= CNT_W'(MAX_PAGES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                total_reg <= cfg_data;
            end
            if (cmd.clr_wr || cmd.mark_wr)
            begin
                w_reg <= w_reg + WORD_IDX_W'(1);
            end
            else if (cmd.load)
            begin
                w_reg <= s_tuser ? free_first[PAGE_IDX_W-1:BIT_IDX_W] : '0;
            end
            else if (cmd.scan_step)
            begin
                if (scan_found)
                begin
                    w_reg <= scan_start[PAGE_IDX_W-1:BIT_IDX_W];
                end
                else if (c_reg == '1)
                begin
                    w_reg <= w_reg + WORD_IDX_W'(1);
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cnt_reg      <= in_cnt;
            limit_reg    <= limit_calc;
            is_free_reg  <= s_tuser;
            set_bits_reg <= (s_tuser == CMD_ALLOC);
            c_reg        <= '0;
            len_reg      <= '0;
            start_reg    <= '0;
            res_addr_reg <= '0;
            res_ok_reg   <= (s_tuser == CMD_FREE);
            lo_reg       <= free_first;
            hi_reg       <= free_hi;
        end
        else if (cmd.scan_step)
        begin
            if (scan_found)
            begin
                lo_reg       <= scan_start;
                hi_reg       <= alloc_hi_sum[CNT_W-1:0];
                res_addr_reg <= {scan_start[PAGE_IDX_W-1:0], PAGE_SHIFT'(0)};
                res_ok_reg   <= 1'b1;
            end
            else
            begin
                len_reg   <= scan_len;
                start_reg <= scan_start;
                c_reg     <= c_reg + CHUNK_W'(1);
            end
        end
        if (cmd.out_load)
        begin
            out_addr_reg <= res_addr_reg;
            out_ok_reg   <= res_ok_reg;
        end
    end

    assign status.clr_last   = (w_reg == '1);
    assign status.is_free    = is_free_reg;
    assign status.zero_cnt   = (cnt_reg == '0);
    assign status.free_empty = (lo_reg >= hi_reg);
    assign status.scan_found = scan_found;
    assign status.scan_fail  = scan_stop || ((c_reg == '1) && (w_reg == '1));
    assign status.word_end   = (c_reg == '1);
    assign status.mark_last  = (w_reg == hi_m1[PAGE_IDX_W-1:BIT_IDX_W]);
    assign status.out_busy   = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_addr_reg);
    assign m_tuser  = out_ok_reg;

endmodule

[src/bitmap_page_allocator.sv]
// top level of the bitmap first-fit page allocator
//
// requests enter on the s_ stream: s_tuser is the command (0 allocate, 1 free),
// s_tdata carries the page count and the byte address to free. each request gives
// one result on the m_ stream: m_tdata is the byte address of the allocated run
// (0 on failure and for a free), m_tuser is the ok flag.
// the user is to write the page total through cfg_valid/cfg_data only while the
// block is idle; the block does not enforce this. cfg_ready is always high.
// one bitmap word of 64 pages is held in a single-port memory. an allocate reads
// one word and scans it 8 pages per cycle, word by word, until a run is found or
// the limit is reached, then marks the run; a free reads and writes back each word
// it touches. one request is worked at a time.
// after reset a clearing pass writes all 1024 bitmap words and marks every page
// used; no request is taken during it, configuration writes are.
// the result register lets the block go idle while m_tready is low; a new
// request is accepted then, and its result waits until the previous one is taken.
module bitmap_page_allocator
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bpa_pkg::IN_DATA_W-1:0]   s_tdata,  // page_count, base_address, zero pad
    input  logic                            s_tuser,  // command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bpa_pkg::OUT_DATA_W-1:0]  m_tdata,  // address, zero pad
    output logic                            m_tuser,  // ok
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bpa_pkg::CNT_W-1:0]       cfg_data
);
    import bpa_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    bpa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bpa_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data)
    );

endmodule
